FILE: src/sstk_pkg.sv
// Package for the segmented stack: command, status and state codes, word types.
// No dependencies; imported by segmented_stack_with_pop_at.
package sstk_pkg;

   localparam logic [4:0] LIMIT_RESET = 5'd10;

   typedef enum logic [1:0] {
      CMD_PUSH     = 2'd0,
      CMD_POP      = 2'd1,
      CMD_POP_AT   = 2'd2,
      CMD_READ_TOP = 2'd3
   } sstk_cmd_type;

   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_EMPTY  = 2'd1,
      STAT_NO_SUB = 2'd2,
      STAT_FULL   = 2'd3
   } sstk_status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SEL,
      S_FILL,
      S_EXEC,
      S_OPEN,
      S_TOP_SEL,
      S_TOP_FILL,
      S_TOP_READ,
      S_DONE
   } sstk_state_type;

   typedef struct packed {
      sstk_cmd_type       cmd;
      logic signed [31:0] push_value;
      logic [2:0]         substack_index;
   } sstk_req_type;

   typedef struct packed {
      sstk_status_type    status;
      logic signed [31:0] top_value;
      logic [3:0]         substack_count;
   } sstk_rsp_type;

endpackage

FILE: src/segmented_stack_with_pop_at.sv
// Segmented stack with pop-at: sequencer, order table and entry memory; depends on sstk_pkg.
// Steps: select, fill, execute, top select, top fill, top read, done; a push that opens a
// new sub-stack adds an open step and executes again, read-top and rejected pops skip fill
// and execute, and a held result stalls in done. One request at a time: a new one is taken
// only in idle, as the single memory port and the sequential slot and fill lookups serialise it.
// Reset: synchronous; stack empty, order table identity, limit 10. Memory is not cleared.
module segmented_stack_with_pop_at #(
   parameter int MAX_SUBSTACKS  = 8,
   parameter int SUBSTACK_DEPTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  sstk_pkg::sstk_req_type req_word,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output sstk_pkg::sstk_rsp_type rsp_word,
   input  logic                 csr_wr_en,
   input  logic [4:0]           csr_wr_data
);
   import sstk_pkg::*;

   localparam int LW    = $clog2(MAX_SUBSTACKS);
   localparam int FW    = $clog2(SUBSTACK_DEPTH + 1);
   localparam int DW    = (SUBSTACK_DEPTH > 1) ? $clog2(SUBSTACK_DEPTH) : 1;
   localparam int AW    = $clog2(MAX_SUBSTACKS * SUBSTACK_DEPTH);
   localparam int CW    = (FW > 5) ? FW : 5;
   localparam int IW    = (LW > 3) ? LW : 3;
   localparam int SW    = (LW + 1 > 4) ? LW + 1 : 4;
   localparam int WORDS = MAX_SUBSTACKS * SUBSTACK_DEPTH;
   localparam logic [LW-1:0] LAST_MAX = LW'(MAX_SUBSTACKS - 1);

   sstk_state_type  state_ff, state_in;
   sstk_cmd_type    cmd_ff, cmd_in;
   logic [31:0]     val_ff, val_in;
   logic [2:0]      idx_ff, idx_in;
   sstk_status_type status_ff, status_in;
   logic [LW-1:0]   target_ff, target_in;
   logic [LW-1:0]   phys_ff, phys_in;
   logic [FW-1:0]   fill_ff, fill_in;
   logic [LW-1:0]   last_ff, last_in;
   logic            empty_ff, empty_in;
   logic [4:0]      limit_ff, limit_in;
   logic [LW-1:0]   slot_order_ff [MAX_SUBSTACKS];
   logic [LW-1:0]   slot_order_in [MAX_SUBSTACKS];
   logic [FW-1:0]   fill_count_ff [MAX_SUBSTACKS];
   logic [FW-1:0]   fill_count_in [MAX_SUBSTACKS];
   logic [31:0]     rd_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   sstk_rsp_type    rsp_word_ff, rsp_word_in;
   logic [31:0]     mem [WORDS];

   logic [IW-1:0]   idx_wide;
   logic            no_sub;
   logic            pop_cmd;
   logic [CW-1:0]   eff_limit;
   logic            full_now;
   logic            rsp_load;
   logic            mem_we;
   logic [DW-1:0]   mem_slot;
   logic [AW-1:0]   mem_addr;
   logic [FW-1:0]   fill_dec;
   logic [SW-1:0]   count_wide;

   assign idx_wide   = IW'(idx_ff);
   assign no_sub     = idx_wide > IW'(last_ff);
   assign pop_cmd    = (cmd_ff == CMD_POP) || (cmd_ff == CMD_POP_AT);
   assign full_now   = CW'(fill_ff) >= eff_limit;
   assign rsp_load   = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);
   assign fill_dec   = fill_ff - FW'(1);
   assign mem_slot   = (state_ff == S_EXEC) ? DW'(fill_ff) : DW'(fill_dec);
   assign mem_addr   = AW'(phys_ff) * AW'(SUBSTACK_DEPTH) + AW'(mem_slot);
   assign count_wide = SW'(last_ff) + SW'(1);
   assign mem_we     = (state_ff == S_EXEC) && (cmd_ff == CMD_PUSH) && !full_now;

   always_comb begin
      eff_limit = CW'(limit_ff);
      if (limit_ff == 5'd0) begin
         eff_limit = CW'(1);
      end else if (CW'(limit_ff) > CW'(SUBSTACK_DEPTH)) begin
         eff_limit = CW'(SUBSTACK_DEPTH);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_SEL;
         end
         S_SEL: begin
            if (cmd_ff == CMD_READ_TOP) state_in = S_TOP_SEL;
            else if (pop_cmd && empty_ff) state_in = S_TOP_SEL;
            else if (cmd_ff == CMD_POP_AT && no_sub) state_in = S_TOP_SEL;
            else state_in = S_FILL;
         end
         S_FILL: state_in = S_EXEC;
         S_EXEC: begin
            if (cmd_ff == CMD_PUSH && full_now && last_ff != LAST_MAX) state_in = S_OPEN;
            else state_in = S_TOP_SEL;
         end
         S_OPEN:     state_in = S_EXEC;
         S_TOP_SEL:  state_in = S_TOP_FILL;
         S_TOP_FILL: state_in = S_TOP_READ;
         S_TOP_READ: state_in = S_DONE;
         S_DONE: begin
            if (rsp_load) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = (state_ff == S_IDLE);
      rsp_valid = rsp_valid_ff;
      rsp_word  = rsp_word_ff;
   end

   // datapath
   always_comb begin
      cmd_in        = cmd_ff;
      val_in        = val_ff;
      idx_in        = idx_ff;
      status_in     = status_ff;
      target_in     = target_ff;
      phys_in       = phys_ff;
      fill_in       = fill_ff;
      last_in       = last_ff;
      empty_in      = empty_ff;
      slot_order_in = slot_order_ff;
      fill_count_in = fill_count_ff;
      limit_in      = csr_wr_en ? csr_wr_data : limit_ff;
      rsp_word_in   = rsp_word_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in    = req_word.cmd;
               val_in    = req_word.push_value;
               idx_in    = req_word.substack_index;
               status_in = STAT_OK;
            end
         end
         S_SEL: begin
            target_in = (cmd_ff == CMD_POP_AT) ? LW'(idx_wide) : last_ff;
            phys_in   = slot_order_ff[target_in];
            if (cmd_ff == CMD_READ_TOP || pop_cmd) begin
               if (empty_ff) status_in = STAT_EMPTY;
               else if (cmd_ff == CMD_POP_AT && no_sub) status_in = STAT_NO_SUB;
            end
         end
         S_FILL: fill_in = fill_count_ff[phys_ff];
         S_EXEC: begin
            if (cmd_ff == CMD_PUSH) begin
               if (!full_now) begin
                  fill_count_in[phys_ff] = fill_ff + FW'(1);
                  empty_in               = 1'b0;
               end else if (last_ff == LAST_MAX) begin
                  status_in = STAT_FULL;
               end
            end else begin
               fill_count_in[phys_ff] = fill_dec;
               if (fill_dec == '0) begin
                  if (last_ff != '0) begin
                     // erase the sub-stack: shift later slots down
                     for (int i = 0; i < MAX_SUBSTACKS - 1; i++) begin
                        if (LW'(i) >= target_ff && LW'(i) < last_ff) begin
                           slot_order_in[i] = slot_order_ff[i + 1];
                        end
                     end
                     slot_order_in[last_ff] = phys_ff;
                     last_in                = last_ff - LW'(1);
                  end else begin
                     empty_in = 1'b1;
                  end
               end
            end
         end
         S_OPEN: begin
            last_in = last_ff + LW'(1);
            phys_in = slot_order_ff[last_in];
            fill_in = '0;
         end
         S_TOP_SEL:  phys_in = slot_order_ff[last_ff];
         S_TOP_FILL: fill_in = fill_count_ff[phys_ff];
         S_TOP_READ: begin
         end
         S_DONE: begin
            if (rsp_load) begin
               rsp_word_in.status         = status_ff;
               rsp_word_in.top_value      = empty_ff ? 32'sd0 : rd_ff;
               rsp_word_in.substack_count = count_wide[3:0];
               rsp_valid_in               = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         last_ff      <= '0;
         empty_ff     <= 1'b1;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_SUBSTACKS; i++) begin
            slot_order_ff[i] <= LW'(i);
            fill_count_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         last_ff       <= last_in;
         empty_ff      <= empty_in;
         limit_ff      <= limit_in;
         rsp_valid_ff  <= rsp_valid_in;
         slot_order_ff <= slot_order_in;
         fill_count_ff <= fill_count_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      val_ff      <= val_in;
      idx_ff      <= idx_in;
      status_ff   <= status_in;
      target_ff   <= target_in;
      phys_ff     <= phys_in;
      fill_ff     <= fill_in;
      rsp_word_ff <= rsp_word_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= val_ff;
      if (state_ff == S_TOP_READ) rd_ff <= mem[mem_addr];
   end

`ifndef ASSERT_OFF
   a_empty_base_only: assert property (@(posedge clock) disable iff (reset)
      empty_ff |-> last_ff == '0)
      else $error("empty flag set with more than one sub-stack");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("result word raised outside of done step");

   a_last_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && !empty_ff) |-> fill_count_ff[slot_order_ff[last_ff]] != '0)
      else $error("last sub-stack empty while stack not empty");

   a_full_at_max: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && status_ff == STAT_FULL) |-> last_ff == LAST_MAX)
      else $error("full status with sub-stacks still free");
`endif

endmodule
